// ===== hdl/assert_macros.svh =====
// Assertion macros for the echo pulse range meter.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off during reset.
`define ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  `ASSERT_PROP(label, (ante) |-> (cons))

`endif

// ===== hdl/eprm_pkg.sv =====
// Shared types, constants and codes for the echo pulse range meter.
// No dependencies.
package eprm_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int STAMP_IN_W   = 16;
  localparam int SCALE_W      = 10;
  localparam int DIST_W       = 24;
  localparam int TMO_W        = 8;
  localparam int PROD_W       = COUNTER_BITS + SCALE_W;
  localparam int CMP_W        = (PROD_W > DIST_W) ? PROD_W : DIST_W;

  typedef logic [COUNTER_BITS-1:0] stamp_t;
  typedef logic [SCALE_W-1:0]      scale_t;
  typedef logic [DIST_W-1:0]       dist_t;
  typedef logic [TMO_W-1:0]        tmo_t;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  localparam logic [1:0] REG_SCALE   = 2'd0;
  localparam logic [1:0] REG_MIN     = 2'd1;
  localparam logic [1:0] REG_MAX     = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  localparam scale_t RST_SCALE   = scale_t'(136);
  localparam dist_t  RST_MIN     = dist_t'(7000);
  localparam dist_t  RST_MAX     = dist_t'(300000);
  localparam tmo_t   RST_TIMEOUT = tmo_t'(20);

endpackage

// ===== hdl/echo_pulse_range_meter_core.sv =====
// Echo pulse range meter top level: config registers, echo state, beat pipeline.
// Depends on eprm_pkg, eprm_measure and assert_macros.svh.
//
// One beat is taken every cycle unless in_stall holds it off. A beat lands in an
// input register; when it advances, the echo state is updated and any report
// goes to the output register, so a report is offered on the output once its
// tick leaves the input register. Capture edges give no report; a tick gives at
// most one. The single width multiply and range compare sit between the echo
// state registers and the output register. While a report waits on out_stall,
// the input register still holds one more beat.
module echo_pulse_range_meter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_opcode,
  input  logic [eprm_pkg::STAMP_IN_W-1:0]   in_capture_stamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_report_kind,
  output logic [23:0]                       out_distance,
  output logic                              out_in_range,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  `include "assert_macros.svh"

  eprm_pkg::scale_t scale_r;
  eprm_pkg::dist_t  min_r;
  eprm_pkg::dist_t  max_r;
  eprm_pkg::tmo_t   timeout_r;

  logic             in_valid_r;
  logic             in_opcode_r;
  eprm_pkg::stamp_t in_stamp_r;

  logic             expect_rising_r, expect_rising_nxt;
  eprm_pkg::stamp_t start_stamp_r, start_stamp_nxt;
  eprm_pkg::stamp_t end_stamp_r, end_stamp_nxt;
  logic             echo_done_r, echo_done_nxt;
  eprm_pkg::tmo_t   miss_count_r, miss_count_nxt;

  logic             out_valid_r;
  logic             out_kind_r;
  eprm_pkg::dist_t  out_distance_r;
  logic             out_in_range_r;

  logic             in_accept;
  logic             advance;
  logic             produce;
  logic             timed_out;
  logic [eprm_pkg::TMO_W:0] next_miss;
  eprm_pkg::dist_t  meas_dist;
  logic             meas_ok;
  logic             cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= eprm_pkg::RST_SCALE;
      min_r     <= eprm_pkg::RST_MIN;
      max_r     <= eprm_pkg::RST_MAX;
      timeout_r <= eprm_pkg::RST_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        eprm_pkg::REG_SCALE:   scale_r   <= pwdata[eprm_pkg::SCALE_W-1:0];
        eprm_pkg::REG_MIN:     min_r     <= pwdata[eprm_pkg::DIST_W-1:0];
        eprm_pkg::REG_MAX:     max_r     <= pwdata[eprm_pkg::DIST_W-1:0];
        eprm_pkg::REG_TIMEOUT: timeout_r <= pwdata[eprm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      eprm_pkg::REG_SCALE:   prdata = 32'(scale_r);
      eprm_pkg::REG_MIN:     prdata = 32'(min_r);
      eprm_pkg::REG_MAX:     prdata = 32'(max_r);
      eprm_pkg::REG_TIMEOUT: prdata = 32'(timeout_r);
      default:               prdata = '0;
    endcase
  end

  // beat pipeline
  assign advance   = ~produce | ~out_valid_r | ~out_stall;
  assign in_stall  = in_valid_r & ~advance;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_accept) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_opcode_r <= in_opcode;
      in_stamp_r  <= eprm_pkg::stamp_t'(in_capture_stamp);
    end
  end

  eprm_measure u_measure (
    .start_stamp (start_stamp_r),
    .end_stamp   (end_stamp_r),
    .scale       (scale_r),
    .min_dist    (min_r),
    .max_dist    (max_r),
    .distance    (meas_dist),
    .in_range    (meas_ok)
  );

  assign next_miss = {1'b0, miss_count_r} + 1'b1;
  assign timed_out = next_miss > {1'b0, timeout_r};
  assign produce   = in_valid_r & (in_opcode_r == eprm_pkg::OP_TICK)
                   & (echo_done_r | timed_out);

  always_comb begin
    expect_rising_nxt = expect_rising_r;
    start_stamp_nxt   = start_stamp_r;
    end_stamp_nxt     = end_stamp_r;
    echo_done_nxt     = echo_done_r;
    miss_count_nxt    = miss_count_r;
    if (in_opcode_r == eprm_pkg::OP_EDGE) begin
      if (expect_rising_r) begin
        start_stamp_nxt   = in_stamp_r;
        expect_rising_nxt = 1'b0;
      end else begin
        end_stamp_nxt     = in_stamp_r;
        echo_done_nxt     = 1'b1;
        expect_rising_nxt = 1'b1;
        miss_count_nxt    = '0;
      end
    end else begin
      if (echo_done_r) begin
        echo_done_nxt     = 1'b0;
        expect_rising_nxt = 1'b1;
      end
      if (timed_out) begin
        echo_done_nxt     = 1'b0;
        expect_rising_nxt = 1'b1;
        miss_count_nxt    = '0;
      end else begin
        miss_count_nxt    = next_miss[eprm_pkg::TMO_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_rising_r <= 1'b1;
      start_stamp_r   <= '0;
      end_stamp_r     <= '0;
      echo_done_r     <= 1'b0;
      miss_count_r    <= '0;
    end else if (in_valid_r && advance) begin
      expect_rising_r <= expect_rising_nxt;
      start_stamp_r   <= start_stamp_nxt;
      end_stamp_r     <= end_stamp_nxt;
      echo_done_r     <= echo_done_nxt;
      miss_count_r    <= miss_count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce && advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce && advance) begin
      if (echo_done_r) begin
        out_kind_r     <= eprm_pkg::KIND_MEASURE;
        out_distance_r <= meas_dist;
        out_in_range_r <= meas_ok;
      end else begin
        out_kind_r     <= eprm_pkg::KIND_TIMEOUT;
        out_distance_r <= '0;
        out_in_range_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_report_kind = out_kind_r;
  assign out_distance    = out_distance_r;
  assign out_in_range    = out_in_range_r;

  // checks
  `ASSERT_IMPL(a_timeout_empty,
    out_valid_r && (out_kind_r == eprm_pkg::KIND_TIMEOUT),
    (out_distance_r == '0) && !out_in_range_r)
  `ASSERT_IMPL(a_range_held,
    out_valid_r && out_in_range_r,
    (out_distance_r >= min_r) && (out_distance_r <= max_r))
  `ASSERT_IMPL(a_invalid_zero, out_valid_r && !out_in_range_r, out_distance_r == '0)
  `ASSERT_IMPL(a_echo_end, $rose(echo_done_r), expect_rising_r && (miss_count_r == '0))

endmodule

// ===== hdl/eprm_measure.sv =====
// Pulse width to distance conversion with range check.
// Depends on eprm_pkg.
module eprm_measure (
  input  eprm_pkg::stamp_t start_stamp,
  input  eprm_pkg::stamp_t end_stamp,
  input  eprm_pkg::scale_t scale,
  input  eprm_pkg::dist_t  min_dist,
  input  eprm_pkg::dist_t  max_dist,
  output eprm_pkg::dist_t  distance,
  output logic             in_range
);

  eprm_pkg::stamp_t                  width;
  logic [eprm_pkg::PROD_W-1:0]       prod;
  logic [eprm_pkg::CMP_W-1:0]        prod_x;
  logic [eprm_pkg::CMP_W-1:0]        min_x;
  logic [eprm_pkg::CMP_W-1:0]        max_x;

  // width wraps modulo the counter size
  assign width  = end_stamp - start_stamp;
  assign prod   = eprm_pkg::PROD_W'(width) * eprm_pkg::PROD_W'(scale);
  assign prod_x = eprm_pkg::CMP_W'(prod);
  assign min_x  = eprm_pkg::CMP_W'(min_dist);
  assign max_x  = eprm_pkg::CMP_W'(max_dist);

  assign in_range = (prod_x >= min_x) && (prod_x <= max_x);
  assign distance = in_range ? prod_x[eprm_pkg::DIST_W-1:0] : '0;

endmodule
